@@ rtl/mtt_pkg.sv @@
// ----------------------------------------------------------------------------
// mtt_pkg
// Shared types and codes for the minimum tournament tree.
// ----------------------------------------------------------------------------
package mtt_pkg;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_EXTRACT = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_PEEK    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STATUS_DONE   = 2'd0,
    STATUS_REJECT = 2'd1,
    STATUS_EMPTY  = 2'd2
  } status_e;

  localparam logic REG_LEAVES = 1'b0;
  localparam logic REG_MARKER = 1'b1;

  localparam int unsigned LEAVES_BITS = 5;
  localparam int unsigned MARKER_BITS = 32;
  localparam int unsigned INDEX_BITS  = 4;
  localparam int unsigned FIELD_BITS  = 32;

  localparam logic [LEAVES_BITS-1:0] LEAVES_RESET = 5'd16;
  localparam logic [MARKER_BITS-1:0] MARKER_RESET = 32'hFFFF_FFFF;

endpackage

@@ rtl/min_tournament_tree.sv @@
// ----------------------------------------------------------------------------
// min_tournament_tree
// Minimum winner tree over a fixed set of leaves with an empty marker value.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command per transaction: tuser holds the action
//   (insert, extract, replace, peek), tdata the leaf index and the value.
//   m_axis returns one result per command: tuser holds the status, tdata the
//   returned value, the winner leaf, the root after the command and the
//   empty flag. The APB port sets leaves_in_use (0x0) and empty_marker (0x4).
//   Commands are handled one at a time; s_axis_tready is low while one is
//   in progress. An insert walks up from its leaf; an extract or replace
//   first walks down the H = clog2(LEAF_SLOTS) levels to the winner leaf. A
//   peek, a rejected insert or an empty tree goes straight to the result.
//   The node memory walks one level per cycle, down the winner path and then
//   up along the siblings. After reset a clearing pass over all 2*P - 1 nodes
//   (P = leaves rounded up to a power of two) fills the node memory with the
//   empty marker; no command is taken meanwhile. A stalled m_axis holds its
//   result, and a finished command waits until the output register frees.
// ----------------------------------------------------------------------------
module min_tournament_tree #(
  parameter int unsigned LEAF_SLOTS = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // tdata: leaf_index[3:0], data_value[35:4], zero pad[39:36]
  input  logic [39:0] s_axis_tdata,
  // tuser: action[1:0]
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: returned_value[31:0], best_leaf[35:32], winner_after[67:36],
  //        empty_after[68], zero pad[71:69]
  output logic [71:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import mtt_pkg::*;

  localparam int unsigned H     = $clog2(LEAF_SLOTS);
  localparam int unsigned P     = 1 << H;
  localparam int unsigned NODES = 2 * P - 1;
  localparam int unsigned NW    = H + 1;
  localparam int unsigned LW    = $clog2(H + 1);
  localparam int unsigned VW    = VALUE_BITS;

  localparam logic [63:0]   RST_EXT  = {32'b0, MARKER_RESET};
  localparam logic [VW-1:0] RST_SENT = RST_EXT[VW-1:0];

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DOWN,
    ST_LEAF,
    ST_UP,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [LEAVES_BITS-1:0] leaves_q;
  logic [MARKER_BITS-1:0] marker_q;
  logic [VW-1:0]          root_q;
  logic [NW-1:0]          clr_q;
  logic [NW-1:0]          node_q;
  logic [LW-1:0]          lvl_q;
  logic [VW-1:0]          val_q;
  logic [VW-1:0]          data_q;
  action_e                act_q;
  status_e                status_q;
  logic [VW-1:0]          ret_q;
  logic [INDEX_BITS-1:0]  wleaf_q;
  logic                   mo_valid_q;
  logic [1:0]             mo_status_q;
  logic [FIELD_BITS-1:0]  mo_ret_q;
  logic [INDEX_BITS-1:0]  mo_wleaf_q;
  logic [FIELD_BITS-1:0]  mo_root_q;
  logic                   mo_empty_q;

  logic [VW-1:0] mem [NODES];
  logic [VW-1:0] rd_a_q, rd_b_q;
  logic [NW-1:0] ra_a, ra_b, wa;
  logic [VW-1:0] wd;
  logic          we;

  logic [VW-1:0]         sent;
  logic [63:0]           marker_ext, data_ext;
  logic [VW-1:0]         in_data;
  logic [INDEX_BITS-1:0] in_idx;
  action_e               in_act;
  logic                  in_fire, cfg_wr, out_free, root_empty;
  logic [NW-1:0]         left_n, right_n, pick_n, pick_l, parent_n, leaf_n;
  logic [VW-1:0]         pick_v, up_v;
  logic                  go_right, last_lvl, idx_bad;
  logic [31:0]           wleaf_x;

  function automatic logic [VW-1:0] pick_min(logic [VW-1:0] a, logic [VW-1:0] b,
                                             logic [VW-1:0] s);
    logic [VW-1:0] r;
    if (a == s) begin
      r = b;
    end else if (b == s) begin
      r = a;
    end else begin
      r = (a < b) ? a : b;
    end
    return r;
  endfunction

  function automatic logic [NW-1:0] sibling(logic [NW-1:0] n);
    return n[0] ? NW'(n + NW'(1)) : NW'(n - NW'(1));
  endfunction

  assign marker_ext = {32'b0, marker_q};
  assign sent       = marker_ext[VW-1:0];
  assign data_ext   = {32'b0, s_axis_tdata[35:4]};
  assign in_data    = data_ext[VW-1:0];
  assign in_idx     = s_axis_tdata[3:0];
  assign in_act     = action_e'(s_axis_tuser);
  assign root_empty = (root_q == sent);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mo_valid_q || m_axis_tready;
  assign cfg_wr        = psel && penable && pwrite;
  assign pready        = 1'b1;
  assign prdata        = (paddr[2] == REG_MARKER) ? marker_q
                                                  : {27'b0, leaves_q};

  assign idx_bad = ({27'b0, in_idx} >= {27'b0, leaves_q}) ||
                   (32'(in_idx) >= LEAF_SLOTS);
  assign leaf_n  = NW'(P - 1) + NW'(in_idx);

  // descent step
  assign left_n   = {node_q[NW-2:0], 1'b1};
  assign right_n  = NW'(left_n + NW'(1));
  assign go_right = (rd_a_q != root_q) && (rd_b_q == root_q);
  assign pick_n   = go_right ? right_n : left_n;
  assign pick_v   = go_right ? rd_b_q : rd_a_q;
  assign pick_l   = {pick_n[NW-2:0], 1'b1};
  assign last_lvl = ((32'(lvl_q) + 32'd1) == H);
  assign wleaf_x  = 32'(pick_n) - 32'(P - 1);

  // ascent step
  assign parent_n = NW'(node_q - NW'(1)) >> 1;
  assign up_v     = pick_min(val_q, rd_a_q, sent);

  always_comb begin
    ra_a = NW'(1);
    ra_b = NW'(2);
    we   = 1'b0;
    wa   = node_q;
    wd   = val_q;
    case (state_q)
      ST_CLEAR: begin
        we = 1'b1;
        wa = clr_q;
        wd = RST_SENT;
      end
      ST_DOWN: begin
        ra_a = pick_l;
        ra_b = NW'(pick_l + NW'(1));
      end
      ST_LEAF: begin
        we   = 1'b1;
        ra_a = sibling(node_q);
      end
      ST_UP: begin
        we   = (parent_n != '0);
        wa   = parent_n;
        wd   = up_v;
        ra_a = sibling(parent_n);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra_a];
    rd_b_q <= mem[ra_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaves_q <= LEAVES_RESET;
      marker_q <= MARKER_RESET;
    end else if (cfg_wr && pready) begin
      if (paddr[2] == REG_LEAVES) begin
        leaves_q <= pwdata[LEAVES_BITS-1:0];
      end else begin
        marker_q <= pwdata;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      clr_q      <= '0;
      root_q     <= RST_SENT;
      node_q     <= '0;
      lvl_q      <= '0;
      mo_valid_q <= 1'b0;
    end else begin
      if (mo_valid_q && m_axis_tready) begin
        mo_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= NW'(clr_q + NW'(1));
          if (clr_q == NW'(NODES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            act_q    <= in_act;
            data_q   <= in_data;
            status_q <= STATUS_DONE;
            ret_q    <= sent;
            wleaf_q  <= '0;
            state_q  <= ST_DONE;
            case (in_act)
              ACT_INSERT: begin
                if (idx_bad) begin
                  status_q <= STATUS_REJECT;
                end else begin
                  node_q  <= leaf_n;
                  val_q   <= in_data;
                  state_q <= ST_LEAF;
                end
              end
              ACT_EXTRACT, ACT_REPLACE: begin
                if (root_empty) begin
                  status_q <= STATUS_EMPTY;
                end else begin
                  node_q  <= '0;
                  lvl_q   <= '0;
                  state_q <= ST_DOWN;
                end
              end
              default: begin
                ret_q <= root_q;
              end
            endcase
          end
        end
        ST_DOWN: begin
          node_q <= pick_n;
          lvl_q  <= LW'(lvl_q + LW'(1));
          if (last_lvl) begin
            ret_q   <= pick_v;
            wleaf_q <= wleaf_x[INDEX_BITS-1:0];
            val_q   <= (act_q == ACT_EXTRACT) ? sent : data_q;
            state_q <= ST_LEAF;
          end
        end
        ST_LEAF: begin
          state_q <= ST_UP;
        end
        ST_UP: begin
          node_q <= parent_n;
          val_q  <= up_v;
          if (parent_n == '0) begin
            root_q  <= up_v;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            mo_valid_q <= 1'b1;
            state_q    <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  logic [63:0] ret_ext, root_ext;
  assign ret_ext  = 64'(ret_q);
  assign root_ext = 64'(root_q);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      mo_status_q <= status_q;
      mo_ret_q    <= ret_ext[FIELD_BITS-1:0];
      mo_wleaf_q  <= wleaf_q;
      mo_root_q   <= root_ext[FIELD_BITS-1:0];
      mo_empty_q  <= root_empty;
    end
  end

  assign m_axis_tvalid = mo_valid_q;
  assign m_axis_tuser  = mo_status_q;
  assign m_axis_tdata  = {3'b0, mo_empty_q, mo_root_q, mo_wleaf_q, mo_ret_q};

  a_down_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DOWN) |-> (32'(lvl_q) < H))
    else $error("descent went below the leaf level");

  a_up_not_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LEAF || state_q == ST_UP) |-> (node_q != '0))
    else $error("path update started at the root");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second command taken while one is in progress");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result issued outside completion");

endmodule
